@@ hw/rtl/bde_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_pkg: shared types and helpers for the bounded deque
// Item formats, action and status codes, ring sizing and ring index math.
// ----------------------------------------------------------------------------
package bde_pkg;

  // ring sizing
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = IDX_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

  // word and field widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ACT_W  = 3;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // action codes of an input item
  typedef enum logic [ACT_W-1:0] {
    OP_CREATE     = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_DUMP       = 3'd5
  } op_e;

  // status codes of a result item
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_CREATED = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  // back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP_RD,
    BK_DUMP
  } bk_state_e;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [WORD_W-1:0] data;
    logic                     last;
  } out_item_t;

  // decoded command handed from front to back
  typedef struct packed {
    op_e                      op;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  // ring index plus offset, both below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[IDX_W-1:0];
  endfunction

  // ring index minus one
  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] res;
    if (base == '0) begin
      res = IDX_W'(DEPTH - 1);
    end else begin
      res = base - IDX_W'(1);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bounded_double_ended_queue_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_core: bounded deque of signed words
// Input items carry an action and a word; result items carry a status, a
// word and a last flag. Both channels use valid/ready handshakes.
//
// An item passes a decode register and a two-entry command queue, then the
// sequencer carries it out against a DEPTH-entry ring ram. Create, pushes
// and refused actions finish in the idle state; a pop reads the ram, then
// gives its result from the read state; dump reads the stored entries in
// order and gives one result per cycle while the receiver takes them. The
// ram's single registered read port is why pops and dumps read first.
// Undefined action codes are dropped and give no result.
//
// Reset empties the deque and clears the front index; ring contents are not
// cleared and are never read before being written. When the receiver stalls,
// the result register holds its item, the sequencer waits, and the queue
// and decode register keep taking items until they fill.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire bde_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output bde_pkg::out_item_t     out_item_o
);
  import bde_pkg::*;

  logic dec_valid, dec_ready;
  cmd_t dec_cmd;
  logic seq_valid, seq_ready;
  cmd_t seq_cmd;

  // accept and decode
  bde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (dec_valid),
    .cmd_ready_i (dec_ready),
    .cmd_o       (dec_cmd)
  );

  // command queue
  bde_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (dec_valid),
    .wr_ready_o (dec_ready),
    .wr_cmd_i   (dec_cmd),
    .rd_valid_o (seq_valid),
    .rd_ready_i (seq_ready),
    .rd_cmd_o   (seq_cmd)
  );

  // sequencer and ring store
  bde_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (seq_valid),
    .cmd_ready_o (seq_ready),
    .cmd_i       (seq_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

@@ hw/rtl/bde_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_ram: generic single-write single-read ram
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module bde_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bde_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_front: input stage of the deque
// Accepts items, decodes the action and drops undefined action codes.
// ----------------------------------------------------------------------------
module bde_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire bde_pkg::in_item_t in_item_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output bde_pkg::cmd_t          cmd_o
);
  import bde_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic legal;
  logic accept;

  // stage is free when empty or draining this cycle
  assign in_ready_o = !valid_q || cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // action decode
  always_comb begin
    legal = 1'b0;
    case (in_item_i.action) inside
      OP_CREATE, OP_PUSH_FRONT, OP_PUSH_BACK,
      OP_POP_FRONT, OP_POP_BACK, OP_DUMP: legal = 1'b1;
      default: legal = 1'b0;
    endcase
  end

  // stage register next values
  always_comb begin
    valid_d = valid_q && !cmd_ready_i;
    cmd_d   = cmd_q;
    if (accept) begin
      valid_d = legal;
      if (legal) begin
        cmd_d.op    = op_e'(in_item_i.action);
        cmd_d.value = in_item_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule
`default_nettype wire

@@ hw/rtl/bde_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_queue: short command queue
// Decouples the input stage from the back-end sequencer.
// ----------------------------------------------------------------------------
module bde_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire bde_pkg::cmd_t wr_cmd_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output bde_pkg::cmd_t      rd_cmd_o
);
  import bde_pkg::*;

  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign wr_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bde_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_back: deque sequencer
// Owns the ring store, front index and entry count, carries out commands
// and drives the result register.
// ----------------------------------------------------------------------------
module bde_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire bde_pkg::cmd_t cmd_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bde_pkg::out_item_t out_item_o
);
  import bde_pkg::*;

  bk_state_e         state_q, state_d;
  logic [IDX_W-1:0]  front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  walk_q, walk_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic              out_free;
  logic              is_empty, is_full;
  logic              walk_last;
  logic [CNT_W-1:0]  cnt_m1;

  assign out_free  = !out_valid_q || out_ready_i;
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign cnt_m1    = count_q - CNT_W'(1);
  assign walk_last = ((CNT_W'(walk_q) + CNT_W'(1)) == count_q);

  // ring store
  bde_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && out_free && !is_empty) begin
          if (cmd_i.op == OP_POP_FRONT || cmd_i.op == OP_POP_BACK) begin
            state_d = BK_POP_RD;
          end else if (cmd_i.op == OP_DUMP) begin
            state_d = BK_DUMP;
          end
        end
      end
      BK_POP_RD: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      BK_DUMP: begin
        if (out_free && walk_last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath, ring access and result register
  always_comb begin
    cmd_ready_o = 1'b0;
    front_d     = front_q;
    count_d     = count_q;
    walk_d      = walk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = front_q;
    ram_wdata   = cmd_i.value;
    ram_re      = 1'b0;
    ram_raddr   = front_q;
    case (state_q)
      BK_IDLE: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          out_d.data = '0;
          out_d.last = 1'b1;
          case (cmd_i.op)
            OP_CREATE: begin
              out_valid_d = 1'b1;
              if (!is_empty) begin
                out_d.status = STAT_CREATED;
              end else begin
                ram_we       = 1'b1;
                count_d      = CNT_W'(1);
                out_d.status = STAT_OK;
              end
            end
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              out_valid_d = 1'b1;
              if (is_empty) begin
                out_d.status = STAT_EMPTY;
              end else if (is_full) begin
                out_d.status = STAT_FULL;
              end else begin
                ram_we = 1'b1;
                if (cmd_i.op == OP_PUSH_FRONT) begin
                  front_d   = ring_dec(front_q);
                  ram_waddr = front_d;
                end else begin
                  ram_waddr = ring_add(front_q, count_q[IDX_W-1:0]);
                end
                count_d      = count_q + CNT_W'(1);
                out_d.status = STAT_OK;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (is_empty) begin
                out_valid_d  = 1'b1;
                out_d.status = STAT_EMPTY;
              end else begin
                ram_re = 1'b1;
                if (cmd_i.op == OP_POP_FRONT) begin
                  front_d = ring_add(front_q, IDX_W'(1));
                end else begin
                  ram_raddr = ring_add(front_q, cnt_m1[IDX_W-1:0]);
                end
                count_d = cnt_m1;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                out_valid_d  = 1'b1;
                out_d.status = STAT_EMPTY;
              end else begin
                ram_re = 1'b1;
                walk_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      // read data of the popped entry is ready
      BK_POP_RD: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d.status = STAT_OK;
          out_d.data   = ram_rdata;
          out_d.last   = 1'b1;
        end
      end
      // one entry per result, next read issued as the current one leaves
      BK_DUMP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d.status = STAT_OK;
          out_d.data   = ram_rdata;
          out_d.last   = walk_last;
          if (!walk_last) begin
            walk_d    = walk_q + IDX_W'(1);
            ram_re    = 1'b1;
            ram_raddr = ring_add(front_q, walk_d);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/bde_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_checker: port-level checks for the deque core
// Watches the top-level ports and is bound to the core.
// ----------------------------------------------------------------------------
module bde_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire bde_pkg::in_item_t  in_item_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire bde_pkg::out_item_t out_item_o
);
  import bde_pkg::*;

  // a waiting input item stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("input item withdrawn or changed while waiting");

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result payload changed while stalled");

  // a refusal is a single result with no data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != STAT_OK |->
      out_item_o.last && out_item_o.data == '0)
    else $error("refused action result malformed");

  // no result in the cycle after reset is released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

endmodule

bind bounded_double_ended_queue_core bde_checker u_bde_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire
